// ----- rtl/core/qrs_pkg.sv -----
`default_nettype none
package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int ROOT_W     = 32;
    localparam int COEF_TOL_W = 31;
    localparam int DISC_TOL_W = 63;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_TOL = 2'd1;

    typedef enum logic [1:0] {
        CASE_INF  = 2'd0,
        CASE_NONE = 2'd1,
        CASE_ONE  = 2'd2,
        CASE_TWO  = 2'd3
    } root_case_t;

endpackage
`default_nettype wire

// ----- rtl/core/quadratic_root_solver.sv -----
// Channel  | handshake              | payload
// s_       | s_valid / s_ready      | s_coef_a, s_coef_b, s_coef_c
// m_       | m_valid / m_ready      | m_root_case, m_first_root, m_second_root, m_saturated
// cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One coefficient set per cycle while the output is not stalled. The pipeline has
// three front stages (input, multiply, discriminant), WORD_BITS+1 square root stages,
// two divider setup stages, WORD_BITS+1 quotient stages and the output register.
// Reset clears all valid bits; tolerances reset to 1.
// When the output register holds a result that is not taken, every stage holds.
`default_nettype none
module quadratic_root_solver import qrs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ROOT_W-1:0]     s_coef_a,
    input  wire logic [ROOT_W-1:0]     s_coef_b,
    input  wire logic [ROOT_W-1:0]     s_coef_c,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_root_case,
    output logic [ROOT_W-1:0]          m_first_root,
    output logic [ROOT_W-1:0]          m_second_root,
    output logic                       m_saturated,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int W    = WORD_BITS;
    localparam int SB   = W + 1;
    localparam int DW   = 2 * W + 1;
    localparam int NW   = W + 2;
    localparam int DMW  = W + 1;
    localparam int QB   = W + 1;
    localparam int SSW  = 3 + 3 * W;

    logic [COEF_TOL_W-1:0] coef_tol_reg;
    logic [DISC_TOL_W-1:0] disc_tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_tol_reg <= COEF_TOL_W'(1);
            disc_tol_reg <= DISC_TOL_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COEF_TOL: coef_tol_reg <= cfg_data[COEF_TOL_W-1:0];
                CFG_DISC_TOL: disc_tol_reg <= cfg_data[DISC_TOL_W-1:0];
                default: ;
            endcase
        end
    end

    logic ce;
    logic m_valid_reg;

    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;

    // front: multiply and classify
    logic          f_valid, f_lin;
    logic [DW-1:0] f_d;
    root_case_t    f_case;
    logic [W-1:0]  f_a, f_b, f_c;

    qrs_front #(.W(W), .DW(DW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid && ce),
        .coef_a    (s_coef_a),
        .coef_b    (s_coef_b),
        .coef_c    (s_coef_c),
        .coef_tol  (coef_tol_reg),
        .disc_tol  (disc_tol_reg),
        .out_valid (f_valid),
        .out_d     (f_d),
        .out_case  (f_case),
        .out_lin   (f_lin),
        .out_a     (f_a),
        .out_b     (f_b),
        .out_c     (f_c)
    );

    // square root of the discriminant
    logic           q_valid;
    logic [SB-1:0]  q_root;
    logic [SSW-1:0] q_side;

    qrs_isqrt #(.SB(SB), .SW(SSW)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (f_valid),
        .in_d      ({1'b0, f_d}),
        .in_side   ({2'(f_case), f_lin, f_a, f_b, f_c}),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_side)
    );

    root_case_t   sq_case;
    logic         sq_lin;
    logic [W-1:0] sq_a, sq_b, sq_c;

    assign sq_case = root_case_t'(q_side[SSW-1:SSW-2]);
    assign sq_lin  = q_side[3*W];
    assign sq_a    = q_side[3*W-1:2*W];
    assign sq_b    = q_side[2*W-1:W];
    assign sq_c    = q_side[W-1:0];

    // numerators and divisor
    logic [NW:0]  bx, cx, sx, nb, num0, num1;
    logic [DMW:0] den;

    assign bx   = (NW+1)'($signed(sq_b));
    assign cx   = (NW+1)'($signed(sq_c));
    assign sx   = (NW+1)'(q_root);
    assign nb   = ~bx + 1'b1;
    assign num0 = (sq_case == CASE_TWO) ? (nb - sx) : (sq_lin ? (~cx + 1'b1) : nb);
    assign num1 = nb + sx;
    assign den  = sq_lin ? (DMW+1)'($signed(sq_b)) : {(DMW)'($signed(sq_a)), 1'b0};

    logic          d_valid;
    logic [QB-1:0] d_q0, d_q1;
    logic [1:0]    d_ovf, d_neg, d_nz, d_side;

    qrs_div #(.NW(NW), .DMW(DMW), .F(FRAC_BITS), .QB(QB), .SW(2)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (q_valid),
        .in_num0   (num0),
        .in_num1   (num1),
        .in_den    (den),
        .in_side   (2'(sq_case)),
        .out_valid (d_valid),
        .out_q0    (d_q0),
        .out_q1    (d_q1),
        .out_ovf   (d_ovf),
        .out_neg   (d_neg),
        .out_nz    (d_nz),
        .out_side  (d_side)
    );

    // saturate, sign and select
    logic [QB-1:0]     lane_q   [0:1];
    logic [ROOT_W-1:0] lane_root[0:1];
    logic [1:0]        lane_sat;

    assign lane_q[0] = d_q0;
    assign lane_q[1] = d_q1;

    for (genvar l = 0; l < 2; l++) begin : g_sat
        logic [QB-1:0] limit, qm, val;
        logic          clip;

        assign limit = d_neg[l] ? (QB'(1) << (W - 1)) : ((QB'(1) << (W - 1)) - 1'b1);
        assign clip  = d_ovf[l] || (lane_q[l] > limit);
        assign qm    = clip ? limit : lane_q[l];
        assign val   = d_neg[l] ? (~qm + 1'b1) : qm;
        assign lane_root[l] = d_nz[l] ? ROOT_W'($signed(val[W-1:0])) : '0;
        assign lane_sat[l]  = d_nz[l] && clip;
    end

    root_case_t        o_case;
    logic              has_one, has_two;
    root_case_t        case_reg;
    logic [ROOT_W-1:0] first_reg, second_reg;
    logic              sat_reg;

    assign o_case  = root_case_t'(d_side);
    assign has_two = (o_case == CASE_TWO);
    assign has_one = (o_case == CASE_ONE) || has_two;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            case_reg   <= o_case;
            first_reg  <= has_one ? lane_root[0] : '0;
            second_reg <= has_two ? lane_root[1] : '0;
            sat_reg    <= (has_one && lane_sat[0]) || (has_two && lane_sat[1]);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_root_case   = 2'(case_reg);
    assign m_first_root  = first_reg;
    assign m_second_root = second_reg;
    assign m_saturated   = sat_reg;

`ifndef SYNTH
    a_inf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (case_reg == CASE_INF) |-> (first_reg == '0) && (second_reg == '0) && !sat_reg)
        else $error("infinite-roots result carries a root or saturation");

    a_second_only_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (case_reg != CASE_TWO) |-> (second_reg == '0))
        else $error("second root set without two roots");

    a_none_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((case_reg == CASE_INF) || (case_reg == CASE_NONE)) |-> !sat_reg)
        else $error("saturation flagged with no root reported");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/qrs_front.sv -----
`default_nettype none
module qrs_front import qrs_pkg::*; #(
    parameter int W  = WORD_BITS_DEF,
    parameter int DW = 2 * W + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  ce,
    input  wire logic                  in_valid,
    input  wire logic [ROOT_W-1:0]     coef_a,
    input  wire logic [ROOT_W-1:0]     coef_b,
    input  wire logic [ROOT_W-1:0]     coef_c,
    input  wire logic [COEF_TOL_W-1:0] coef_tol,
    input  wire logic [DISC_TOL_W-1:0] disc_tol,
    output logic                       out_valid,
    output logic [DW-1:0]              out_d,
    output root_case_t                 out_case,
    output logic                       out_lin,
    output logic [W-1:0]               out_a,
    output logic [W-1:0]               out_b,
    output logic [W-1:0]               out_c
);

    localparam int CTW = (W > COEF_TOL_W) ? W : COEF_TOL_W;
    localparam int DTW = (DW > DISC_TOL_W) ? DW : DISC_TOL_W;

    // stage A: input register
    logic         va_reg;
    logic [W-1:0] a_a_reg, b_a_reg, c_a_reg;

    // stage B: magnitudes multiplied, zero tests
    logic           vb_reg;
    logic [2*W-1:0] bsq_reg, ac_reg;
    logic           sd_reg, za_reg, zb_reg, zc_reg;
    logic [W-1:0]   a_b_reg, b_b_reg, c_b_reg;

    // stage C: discriminant and classification
    logic         vc_reg;
    logic [DW-1:0] d_reg;
    root_case_t   case_reg;
    logic         lin_reg;
    logic [W-1:0] a_c_reg, b_c_reg, c_c_reg;

    logic [W-1:0] am, bm, cm;
    logic         za_next, zb_next, zc_next;

    assign am = a_a_reg[W-1] ? (~a_a_reg + 1'b1) : a_a_reg;
    assign bm = b_a_reg[W-1] ? (~b_a_reg + 1'b1) : b_a_reg;
    assign cm = c_a_reg[W-1] ? (~c_a_reg + 1'b1) : c_a_reg;
    assign za_next = CTW'(am) < CTW'(coef_tol);
    assign zb_next = CTW'(bm) < CTW'(coef_tol);
    assign zc_next = CTW'(cm) < CTW'(coef_tol);

    logic [DW-1:0] bq, ac4, d_next;
    logic          bq_ge, dneg, dsmall, lin_next;
    root_case_t    case_next;

    assign bq    = DW'(bsq_reg);
    assign ac4   = DW'({ac_reg, 2'b00});
    assign bq_ge = bq >= ac4;

    always_comb begin
        if (sd_reg) begin
            d_next = bq + ac4;
        end else if (bq_ge) begin
            d_next = bq - ac4;
        end else begin
            d_next = ac4 - bq;
        end
        dneg   = !sd_reg && !bq_ge;
        dsmall = DTW'(d_next) < DTW'(disc_tol);
        lin_next = 1'b0;
        priority if (za_reg && zb_reg && zc_reg) begin
            case_next = CASE_INF;
        end else if (za_reg) begin
            case_next = zb_reg ? CASE_NONE : CASE_ONE;
            lin_next  = !zb_reg;
        end else if (dneg) begin
            case_next = CASE_NONE;
        end else if (dsmall) begin
            case_next = CASE_ONE;
        end else begin
            case_next = CASE_TWO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (ce) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_a_reg  <= coef_a[W-1:0];
            b_a_reg  <= coef_b[W-1:0];
            c_a_reg  <= coef_c[W-1:0];

            bsq_reg  <= bm * bm;
            ac_reg   <= am * cm;
            sd_reg   <= a_a_reg[W-1] ^ c_a_reg[W-1];
            za_reg   <= za_next;
            zb_reg   <= zb_next;
            zc_reg   <= zc_next;
            a_b_reg  <= a_a_reg;
            b_b_reg  <= b_a_reg;
            c_b_reg  <= c_a_reg;

            d_reg    <= d_next;
            case_reg <= case_next;
            lin_reg  <= lin_next;
            a_c_reg  <= a_b_reg;
            b_c_reg  <= b_b_reg;
            c_c_reg  <= c_b_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_d     = d_reg;
    assign out_case  = case_reg;
    assign out_lin   = lin_reg;
    assign out_a     = a_c_reg;
    assign out_b     = b_c_reg;
    assign out_c     = c_c_reg;

endmodule
`default_nettype wire

// ----- rtl/core/qrs_isqrt.sv -----
`default_nettype none
module qrs_isqrt #(
    parameter int SB = 33,
    parameter int SW = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            ce,
    input  wire logic            in_valid,
    input  wire logic [2*SB-1:0] in_d,
    input  wire logic [SW-1:0]   in_side,
    output logic                 out_valid,
    output logic [SB-1:0]        out_root,
    output logic [SW-1:0]        out_side
);

    localparam int RMW = SB + 2;
    localparam int TW  = SB + 4;

    logic [RMW-1:0]  rem_reg  [0:SB-1];
    logic [SB-1:0]   root_reg [0:SB-1];
    logic [2*SB-1:0] dsh_reg  [0:SB-1];
    logic [SW-1:0]   side_reg [0:SB-1];
    logic            v_reg    [0:SB-1];

    // one root bit per stage, restoring digit recurrence
    for (genvar k = 0; k < SB; k++) begin : g_step
        logic [RMW-1:0]  rem_in;
        logic [SB-1:0]   root_in;
        logic [2*SB-1:0] dsh_in;
        logic [SW-1:0]   side_in;
        logic            v_in;
        logic [TW-1:0]   t, trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign dsh_in  = in_d;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign dsh_in  = dsh_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        assign t     = {rem_in, dsh_in[2*SB-1:2*SB-2]};
        assign trial = TW'({root_in, 2'b01});
        assign ge    = t >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (ce) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= ge ? RMW'(t - trial) : RMW'(t);
                root_reg[k] <= {root_in[SB-2:0], ge};
                dsh_reg[k]  <= {dsh_in[2*SB-3:0], 2'b00};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[SB-1];
    assign out_root  = root_reg[SB-1];
    assign out_side  = side_reg[SB-1];

endmodule
`default_nettype wire

// ----- rtl/core/qrs_div.sv -----
`default_nettype none
module qrs_div #(
    parameter int NW  = 34,
    parameter int DMW = 33,
    parameter int F   = 16,
    parameter int QB  = 33,
    parameter int SW  = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          ce,
    input  wire logic          in_valid,
    input  wire logic [NW:0]   in_num0,
    input  wire logic [NW:0]   in_num1,
    input  wire logic [DMW:0]  in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QB-1:0]      out_q0,
    output logic [QB-1:0]      out_q1,
    output logic [1:0]         out_ovf,
    output logic [1:0]         out_neg,
    output logic [1:0]         out_nz,
    output logic [SW-1:0]      out_side
);

    localparam int NFW = NW + F;
    localparam int HW  = NFW - QB;
    localparam int CW  = (HW > DMW) ? HW : DMW;

    // magnitude stage
    logic            vm_reg;
    logic [NW-1:0]   nm_reg [0:1];
    logic [DMW-1:0]  dm_m_reg;
    logic [1:0]      neg_m_reg;
    logic [SW-1:0]   side_m_reg;

    logic [NW:0]     num_in [0:1];
    logic [DMW:0]    den_mag;

    assign num_in[0] = in_num0;
    assign num_in[1] = in_num1;
    assign den_mag   = in_den[DMW] ? (~in_den + 1'b1) : in_den;

    // step stages; index 0 holds the overflow check and the partial remainder
    logic [DMW-1:0] rem_reg [0:QB][0:1];
    logic [QB-1:0]  lq_reg  [0:QB][0:1];
    logic [DMW-1:0] dm_reg  [0:QB];
    logic [1:0]     ovf_reg [0:QB];
    logic [1:0]     neg_reg [0:QB];
    logic [1:0]     nz_reg  [0:QB];
    logic [SW-1:0]  side_reg[0:QB];
    logic           v_reg   [0:QB];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [NW:0]    nmag;
        logic [NFW-1:0] n_sh;
        logic [HW-1:0]  hi;

        assign nmag = num_in[l][NW] ? (~num_in[l] + 1'b1) : num_in[l];
        assign n_sh = {nm_reg[l], {F{1'b0}}};
        assign hi   = n_sh[NFW-1:QB];

        always_ff @(posedge aclk) begin
            if (ce) begin
                nm_reg[l]       <= nmag[NW-1:0];
                neg_m_reg[l]    <= num_in[l][NW] ^ in_den[DMW];
                rem_reg[0][l]   <= DMW'(hi);
                lq_reg[0][l]    <= n_sh[QB-1:0];
                ovf_reg[0][l]   <= CW'(hi) >= CW'(dm_m_reg);
                nz_reg[0][l]    <= nm_reg[l] != '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
        end else if (ce) begin
            vm_reg   <= in_valid;
            v_reg[0] <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dm_m_reg    <= den_mag[DMW-1:0];
            side_m_reg  <= in_side;
            dm_reg[0]   <= dm_m_reg;
            neg_reg[0]  <= neg_m_reg;
            side_reg[0] <= side_m_reg;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DMW:0] r2;
            logic         ge;

            assign r2 = {rem_reg[k-1][l], lq_reg[k-1][l][QB-1]};
            assign ge = r2 >= {1'b0, dm_reg[k-1]};

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k][l] <= ge ? DMW'(r2 - {1'b0, dm_reg[k-1]}) : DMW'(r2);
                    lq_reg[k][l]  <= {lq_reg[k-1][l][QB-2:0], ge};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (ce) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dm_reg[k]   <= dm_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                nz_reg[k]   <= nz_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign out_q0    = lq_reg[QB][0];
    assign out_q1    = lq_reg[QB][1];
    assign out_ovf   = ovf_reg[QB];
    assign out_neg   = neg_reg[QB];
    assign out_nz    = nz_reg[QB];
    assign out_side  = side_reg[QB];

endmodule
`default_nettype wire

// ----- test/tb_quadratic_root_solver.sv -----
`default_nettype none
module tb_quadratic_root_solver;
    import qrs_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = 80;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } coef_set_t;

    typedef struct packed {
        root_case_t  rcase;
        logic [31:0] r1;
        logic [31:0] r2;
        logic        sat;
    } roots_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [31:0] s_coef_a = '0, s_coef_b = '0, s_coef_c = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_root_case;
    logic [31:0] m_first_root, m_second_root;
    logic m_saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_COEF_TOL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    quadratic_root_solver DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor copy of the tolerance registers
    logic [30:0] coef_tol = 31'd1;
    logic [62:0] disc_tol = 63'd1;

    coef_set_t pending_sets[$];
    roots_t expected_roots[$];
    int errors = 0;
    bit calm = 1'b0;       // no idling near the end
    bit hold_sink = 1'b0;  // long receiver stall
    bit pause_src = 1'b0;

    function automatic logic [63:0] mag64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] fixed_div(longint num, longint den, ref bit sat);
        logic [63:0] nm, dm, lim;
        logic [127:0] q;
        bit neg;
        nm = mag64(num);
        dm = mag64(den);
        neg = (num < 0) != (den < 0);
        if (nm == 0) return 32'd0;
        if (dm == 0) begin
            sat = 1'b1;
            return num < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        q = ({64'd0, nm} << FRAC) / {64'd0, dm};
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > {64'd0, lim}) begin
            sat = 1'b1;
            q = {64'd0, lim};
        end
        return neg ? 32'(-q[63:0]) : q[31:0];
    endfunction

    function automatic logic [63:0] isqrt128(logic [127:0] d);
        logic [63:0] res, t;
        res = 0;
        for (int i = 40; i >= 0; i--) begin
            t = res | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= d) res = t;
        end
        return res;
    endfunction

    function automatic roots_t solve_roots(coef_set_t s);
        longint a, b, c, sq;
        logic [127:0] bsq, ac4, d;
        bit za, zb, zc, sat, dneg;
        roots_t r;
        a = longint'($signed(s.a));
        b = longint'($signed(s.b));
        c = longint'($signed(s.c));
        za = mag64(a) < coef_tol;
        zb = mag64(b) < coef_tol;
        zc = mag64(c) < coef_tol;
        sat = 1'b0;
        dneg = 1'b0;
        r = '{CASE_NONE, 32'd0, 32'd0, 1'b0};
        if (za && zb && zc) begin
            r.rcase = CASE_INF;
        end else if (za) begin
            if (!zb) begin
                r.rcase = CASE_ONE;
                r.r1 = fixed_div(-c, b, sat);
            end
        end else begin
            bsq = {64'd0, mag64(b)} * {64'd0, mag64(b)};
            ac4 = ({64'd0, mag64(a)} * {64'd0, mag64(c)}) << 2;
            if ((a < 0) != (c < 0)) d = bsq + ac4;
            else if (bsq >= ac4) d = bsq - ac4;
            else dneg = 1'b1;
            if (dneg) begin
                r.rcase = CASE_NONE;
            end else if (d < {65'd0, disc_tol}) begin
                r.rcase = CASE_ONE;
                r.r1 = fixed_div(-b, 2 * a, sat);
            end else begin
                sq = longint'(isqrt128(d));
                r.rcase = CASE_TWO;
                r.r1 = fixed_div(-b - sq, 2 * a, sat);
                r.r2 = fixed_div(-b + sq, 2 * a, sat);
            end
        end
        r.sat = sat;
        return r;
    endfunction

    // driver
    int src_gap = 0;
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            expected_roots.push_back(solve_roots({s_coef_a, s_coef_b, s_coef_c}));
            void'(pending_sets.pop_front());
        end
        if (s_valid && !s_ready) begin
            // hold payload
        end else if (src_gap > 0) begin
            src_gap <= src_gap - 1;
            s_valid <= 1'b0;
        end else if (!calm && !pause_src && $urandom_range(0, 7) == 0) begin
            src_gap <= $urandom_range(0, 3);
            s_valid <= 1'b0;
        end else begin
            if (aresetn && !pause_src && pending_sets.size() > 0) begin
                s_valid <= 1'b1;
                {s_coef_a, s_coef_b, s_coef_c} <= pending_sets[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    int sink_gap = 0;
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (expected_roots.size() == 0) begin
                $display("%0t: unexpected transaction case=%0d r1=%h r2=%h sat=%0d", $time,
                         m_root_case, m_first_root, m_second_root, m_saturated);
                errors++;
            end else begin
                roots_t e;
                e = expected_roots.pop_front();
                if (m_root_case != e.rcase) begin
                    $display("%0t: root_case exp %0d act %0d", $time, e.rcase, m_root_case);
                    errors++;
                end
                if (m_first_root != e.r1) begin
                    $display("%0t: first_root exp %h act %h", $time, e.r1, m_first_root);
                    errors++;
                end
                if (m_second_root != e.r2) begin
                    $display("%0t: second_root exp %h act %h", $time, e.r2, m_second_root);
                    errors++;
                end
                if (m_saturated != e.sat) begin
                    $display("%0t: saturated exp %0d act %0d", $time, e.sat, m_saturated);
                    errors++;
                end
            end
        end
        if (hold_sink) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic wait_drained();
        while (pending_sets.size() != 0 || s_valid || expected_roots.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_COEF_TOL) coef_tol = val[30:0];
        else disc_tol = val[62:0];
    endtask

    function automatic logic [31:0] rand_coef(int sz);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 4)) - 2);
            3: return $urandom();
            default: return 32'(($urandom_range(0, 2 * sz) - sz) <<< $urandom_range(8, 18));
        endcase
    endfunction

    // coefficients from chosen roots so two-root and one-root cases are common
    task automatic add_random(int n);
        for (int i = 0; i < n; i++) begin
            int p, q, k;
            coef_set_t s;
            k = $urandom_range(0, 9);
            if (k < 5) begin
                p = $urandom_range(0, 40) - 20;
                q = (k == 0) ? p : $urandom_range(0, 40) - 20;
                s.a = 32'(($urandom_range(1, 8)) <<< 16);
                if ($urandom_range(0, 1)) s.a = -s.a;
                s.b = 32'(-($signed(s.a) >>> 16) * (p + q)) <<< 16;
                s.c = 32'(($signed(s.a) >>> 16) * p * q) <<< 16;
                s.c = s.c ^ 32'($urandom_range(0, 3));
            end else begin
                s = {rand_coef(8), rand_coef(64), rand_coef(64)};
            end
            pending_sets.push_back(s);
        end
    endtask

    task automatic add_set(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        pending_sets.push_back({a, b, c});
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed
        add_set(0, 0, 0);
        add_set(0, 0, ONE);
        add_set(0, 2 * ONE, -6 * ONE);
        add_set(ONE, 0, ONE);
        add_set(ONE, -2 * ONE, ONE);
        add_set(ONE, -3 * ONE, 2 * ONE);
        add_set(-ONE, 3 * ONE, -2 * ONE);
        add_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_set(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_set(1, 32'h7FFF_FFFF, 0);
        add_set(0, 1, 32'h8000_0000);
        add_set(ONE, 32'h7FFF_FFFF, 32'h8000_0000);
        add_set(1, 2, 1);
        add_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(CFG_COEF_TOL, 0);
        write_reg(CFG_DISC_TOL, 0);
        add_set(0, 0, 0);
        add_set(0, 0, ONE);
        add_set(0, 0, 32'h8000_0000);
        add_set(0, 5, 0);
        add_set(ONE, -2 * ONE, ONE);
        add_random(150);
        wait_drained();
        write_reg(CFG_COEF_TOL, 64'h7FFF_FFFF);
        write_reg(CFG_DISC_TOL, 64'h7FFF_FFFF_FFFF_FFFF);
        add_random(100);
        wait_drained();
        write_reg(CFG_COEF_TOL, 64'h0000_1000);
        write_reg(CFG_DISC_TOL, 64'h0000_0100_0000_0000);
        add_random(150);
        // receiver holds off while the sender keeps offering
        hold_sink = 1'b1;
        repeat (200) @(posedge aclk);
        hold_sink = 1'b0;
        wait_drained();
        write_reg(CFG_COEF_TOL, 1);
        write_reg(CFG_DISC_TOL, 1);
        add_random(300);
        // sender pauses until every result is back
        while (pending_sets.size() > 150) @(posedge aclk);
        pause_src = 1'b1;
        while (s_valid) @(posedge aclk);
        while (expected_roots.size() != 0) @(posedge aclk);
        pause_src = 1'b0;
        while (pending_sets.size() > 0) @(posedge aclk);
        calm = 1'b1;
        add_random(330);
        wait_drained();
        if (errors == 0)
            $display("tb_quadratic_root_solver: PASS");
        else
            $display("tb_quadratic_root_solver: FAIL");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_quadratic_root_solver: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_isqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver.sv
test/tb_quadratic_root_solver.sv
